@@ hw/rtl/hex_circle_span_generator_unit_assert.svh @@
// Assertion macros for the hex circle span generator unit.
`ifndef HEX_CIRCLE_SPAN_GENERATOR_UNIT_ASSERT_SVH
`define HEX_CIRCLE_SPAN_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HCSG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HCSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HCSG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define HCSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/hcsg_pkg.sv @@
// Shared types and constants for the hex circle span generator.
package hcsg_pkg;

  localparam int COORD_BITS     = 10;
  localparam int RADIUS_BITS    = 5;
  localparam int DIM_BITS       = 11;
  localparam int INDEX_BITS     = 6;
  localparam int CFG_INDEX_BITS = 1;
  localparam int DIM_LIMIT      = 1 << COORD_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_HEIGHT = 1'd1;

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
  } hcsg_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] span_start;
    logic [COORD_BITS-1:0] span_end;
    logic                  visible;
    logic                  last;
  } hcsg_out_t;

  typedef struct packed {
    logic load;
    logic advance;
  } hcsg_cmd_t;

  typedef struct packed {
    logic scan_done;
  } hcsg_status_t;

endpackage

@@ hw/rtl/hcsg_ctrl.sv @@
// Controller state machine for the hex circle span generator.
module hcsg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  hcsg_pkg::hcsg_status_t status,
  output hcsg_pkg::hcsg_cmd_t    cmd,
  output logic                  busy
);
  import hcsg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state == ST_SCAN);
  assign cmd.load    = start && (state == ST_IDLE);
  assign cmd.advance = (state == ST_SCAN);

endmodule

@@ hw/rtl/hcsg_datapath.sv @@
// Datapath of the hex circle span generator: held item, scanline counter, span math.
`include "hex_circle_span_generator_unit_assert.svh"

module hcsg_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hcsg_pkg::hcsg_cmd_t                   cmd,
  input  hcsg_pkg::hcsg_in_t                    request,
  input  logic                                 cfg_write,
  input  logic [hcsg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hcsg_pkg::DIM_BITS-1:0]        cfg_data,
  output hcsg_pkg::hcsg_status_t                status,
  output hcsg_pkg::hcsg_out_t                   result,
  output logic                                 strobe
);
  import hcsg_pkg::*;

  logic [DIM_BITS-1:0]    map_width;
  logic [DIM_BITS-1:0]    map_height;
  logic [COORD_BITS-1:0]  held_center_x;
  logic [COORD_BITS-1:0]  held_center_y;
  logic [RADIUS_BITS-1:0] held_radius;
  logic [INDEX_BITS-1:0]  scan_index;
  hcsg_out_t              line;
  logic                   is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_BITS'(DIM_LIMIT);
      map_height <= DIM_BITS'(DIM_LIMIT);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width  <= cfg_data;
        CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      scan_index    <= '0;
    end else if (cmd.load) begin
      held_center_x <= request.center_x;
      held_center_y <= request.center_y;
      held_radius   <= request.radius;
      scan_index    <= '0;
    end else if (cmd.advance) begin
      scan_index <= is_last ? '0 : scan_index + INDEX_BITS'(1);
    end
  end

  assign is_last          = (scan_index == {held_radius, 1'b0});
  assign status.scan_done = is_last;

  always_comb begin
    logic [INDEX_BITS-1:0] shorts;
    logic [INDEX_BITS:0]   bottom_sum;
    logic [INDEX_BITS-1:0] from_bottom;
    logic                  even_col;
    logic [INDEX_BITS-1:0] hw;
    logic [DIM_BITS-1:0]   w;
    logic [DIM_BITS-1:0]   h;
    logic signed [11:0]    x1;
    logic signed [11:0]    x2;
    logic signed [11:0]    row;
    logic signed [11:0]    w_max;
    logic                  vis;

    shorts      = ({1'b0, held_radius} + INDEX_BITS'(1)) >> 1;
    bottom_sum  = {1'b0, scan_index} + {1'b0, shorts};
    from_bottom = {held_radius, 1'b0} - scan_index;
    even_col    = ~held_center_x[0];
    if (scan_index < shorts) begin
      hw = {scan_index[4:0], 1'b0} + {5'd0, even_col};
    end else if (bottom_sum > {1'b0, held_radius, 1'b0}) begin
      hw = {from_bottom[4:0], 1'b0} + {5'd0, ~even_col};
    end else begin
      hw = {1'b0, held_radius};
    end

    w = (map_width > DIM_BITS'(DIM_LIMIT)) ? DIM_BITS'(DIM_LIMIT) : map_width;
    h = (map_height > DIM_BITS'(DIM_LIMIT)) ? DIM_BITS'(DIM_LIMIT) : map_height;

    x1    = $signed({2'b00, held_center_x}) - $signed({6'd0, hw});
    x2    = $signed({2'b00, held_center_x}) + $signed({6'd0, hw});
    row   = $signed({2'b00, held_center_y}) - $signed({7'd0, held_radius})
          + $signed({6'd0, scan_index});
    w_max = $signed({1'b0, w}) - 12'sd1;
    if (x1 < 12'sd0) begin
      x1 = 12'sd0;
    end
    if (x2 > w_max) begin
      x2 = w_max;
    end
    vis = (row >= 12'sd0) && (row < $signed({1'b0, h})) && (x1 <= x2);

    line.visible    = vis;
    line.last       = is_last;
    line.row        = vis ? row[COORD_BITS-1:0] : '0;
    line.span_start = vis ? x1[COORD_BITS-1:0] : '0;
    line.span_end   = vis ? x2[COORD_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      result <= line;
    end
  end

  `HCSG_ASSERT_NOW(a_strobe_follows_scan, clk, rst, strobe, $past(cmd.advance), "strobe without scan")
  `HCSG_ASSERT_NOW(a_hidden_zero, clk, rst, strobe && !result.visible, (result.row == '0) && (result.span_start == '0) && (result.span_end == '0), "hidden item not zeroed")
  `HCSG_ASSERT_NOW(a_span_order, clk, rst, strobe && result.visible, result.span_start <= result.span_end, "span reversed")
  `HCSG_ASSERT_NEXT(a_last_marked, clk, rst, cmd.advance && status.scan_done, strobe && result.last && (scan_index == '0), "final scanline not marked")

endmodule

@@ hw/rtl/hex_circle_span_generator_unit.sv @@
// Top level of the hex circle span generator unit.
//
//   channel   ports                          handshake
//   input     start, busy, request           taken when start && !busy
//   result    strobe, result                 one cycle, receiver always takes it
//   config    cfg_write, cfg_index, cfg_data taken when cfg_write
//
// The scanline counter in the datapath steps one scanline per cycle, so busy is
// high from the accept edge until the last of the 2*radius+1 scanlines of the
// item is computed. A new item is taken only after busy falls. Each result is
// registered and shows in the cycle after its scanline is computed. Synchronous
// reset sets both map sizes to 1024. The receiver cannot stall the block.
module hex_circle_span_generator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  hcsg_pkg::hcsg_in_t                    request,
  output logic                                 strobe,
  output hcsg_pkg::hcsg_out_t                   result,
  input  logic                                 cfg_write,
  input  logic [hcsg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hcsg_pkg::DIM_BITS-1:0]        cfg_data
);
  import hcsg_pkg::*;

  hcsg_cmd_t    cmd;
  hcsg_status_t status;

  hcsg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  hcsg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result),
    .strobe    (strobe)
  );

endmodule

@@ test/hcsg_span_checker.sv @@
`timescale 1ns / 1ps
// Scanline span checker: predicts the spans of each accepted circle and compares every result.
module hcsg_span_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  hcsg_pkg::hcsg_in_t                  request,
  input  logic                                strobe,
  input  hcsg_pkg::hcsg_out_t                 result,
  input  logic                                cfg_write,
  input  logic [hcsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hcsg_pkg::DIM_BITS-1:0]       cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  lines_checked,
  output int                                  lines_visible
);
  import hcsg_pkg::*;

  localparam int MAX_RADIUS   = 31;
  localparam int REPORT_LIMIT = 200;

  logic [DIM_BITS-1:0] map_width;
  logic [DIM_BITS-1:0] map_height;
  hcsg_out_t           span_queue[$];
  hcsg_out_t           want;

  function automatic int clip_dim(input logic [DIM_BITS-1:0] dim);
    return (int'(dim) > DIM_LIMIT) ? DIM_LIMIT : int'(dim);
  endfunction

  task automatic predict_circle(input hcsg_in_t req);
    int        cx, cy, rad, lines, shorts, top_off, hw, row, x1, x2, w, h;
    hcsg_out_t scan;
    cx  = int'(req.center_x);
    cy  = int'(req.center_y);
    rad = int'(req.radius);
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;
    w       = clip_dim(map_width);
    h       = clip_dim(map_height);
    lines   = 2 * rad + 1;
    shorts  = (rad + 1) / 2;
    top_off = req.center_x[0] ? 0 : 1;
    for (int i = 0; i < lines; i++) begin
      if (i < shorts) hw = 2 * i + top_off;
      else if (i >= lines - shorts) hw = 2 * (lines - 1 - i) + 1 - top_off;
      else hw = rad;
      row = cy - rad + i;
      x1  = cx - hw;
      x2  = cx + hw;
      if (x1 < 0) x1 = 0;
      if (x2 > w - 1) x2 = w - 1;
      scan = '0;
      scan.visible = (row >= 0 && row < h && x1 <= x2);
      if (scan.visible) begin
        scan.row        = COORD_BITS'(row);
        scan.span_start = COORD_BITS'(x1);
        scan.span_end   = COORD_BITS'(x2);
      end
      scan.last = (i == lines - 1);
      span_queue = {span_queue, scan};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      map_width  = DIM_BITS'(DIM_LIMIT);
      map_height = DIM_BITS'(DIM_LIMIT);
      span_queue.delete();
    end else begin
      if (strobe) begin
        if (span_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected scanline, expected none", $time);
            $display("%0t: actual row %0d start %0d end %0d vis %0b last %0b",
                     $time, result.row, result.span_start, result.span_end,
                     result.visible, result.last);
          end
        end else begin
          want = span_queue.pop_front();
          lines_checked++;
          if (result.visible === 1'b1) lines_visible++;
          if (result.row !== want.row || result.span_start !== want.span_start ||
              result.span_end !== want.span_end || result.visible !== want.visible ||
              result.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: scanline mismatch, expected row %0d start %0d end %0d vis %0b last %0b",
                       $time, want.row, want.span_start, want.span_end, want.visible,
                       want.last);
              $display("%0t: actual row %0d start %0d end %0d vis %0b last %0b",
                       $time, result.row, result.span_start, result.span_end,
                       result.visible, result.last);
            end
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAP_WIDTH:  map_width  = cfg_data;
          CFG_MAP_HEIGHT: map_height = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) predict_circle(request);
    end
    pending = span_queue.size();
  end

endmodule

@@ test/tb_hex_circle_span_generator_unit.sv @@
`timescale 1ns / 1ps
// Testbench top: drives circles and map sizes into the span generator and gives the verdict.
module tb_hex_circle_span_generator_unit;
  import hcsg_pkg::*;

  localparam int QUIET_LIMIT      = 1000;
  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 37;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  hcsg_in_t                  request;
  logic                      strobe;
  hcsg_out_t                 result;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0]       cfg_data;
  int                        fail_count;
  int                        pending;
  int                        lines_checked;
  int                        lines_visible;
  int                        circles_sent = 0;
  int                        quiet_cycles = 0;
  int                        phase_width[PHASES];
  int                        phase_height[PHASES];

  hex_circle_span_generator_unit dut (.*);

  hcsg_span_checker span_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item or result for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_circle(input int x, input int y, input int rad);
    request.center_x = COORD_BITS'(x);
    request.center_y = COORD_BITS'(y);
    request.radius   = RADIUS_BITS'(rad);
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    circles_sent++;
  endtask

  task automatic hold_off(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_dim(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    cfg_index = idx;
    cfg_data  = DIM_BITS'(value);
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // bias centers toward the map corners and edges
  function automatic int pick_coord(input int dim);
    int eff, v;
    eff = (dim > DIM_LIMIT) ? DIM_LIMIT : dim;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 40));
      1: v = (eff == 0) ? int'($urandom_range(0, 1023)) : eff - 41 + int'($urandom_range(0, 80));
      2: v = (eff == 0) ? 0 : int'($urandom_range(0, eff - 1));
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  initial begin
    int rad;
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_MAP_WIDTH;
    cfg_data  = '0;
    phase_width  = '{1024, 1, 0, 1024, 2047, 37, 1023, 700};
    phase_height = '{1024, 1, 1024, 0, 2047, 20, 1025, 1024};
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_circle(0, 0, 0);
    send_circle(1023, 1023, 0);
    send_circle(0, 0, 31);
    hold_off(1);
    send_circle(1023, 1023, 31);
    send_circle(1023, 0, 31);
    send_circle(0, 1023, 31);
    hold_off(3);
    send_circle(512, 512, 31);
    send_circle(513, 512, 31);
    send_circle(10, 10, 1);
    send_circle(11, 10, 1);
    hold_off(2);
    send_circle(20, 20, 2);
    send_circle(21, 20, 2);
    send_circle(30, 30, 3);
    send_circle(31, 30, 3);
    send_circle(5, 40, 7);
    hold_off(5);
    send_circle(1022, 500, 30);
    send_circle(1, 1, 31);
    send_circle(682, 341, 21);
    send_circle(341, 682, 10);
    wait_drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        write_dim(CFG_MAP_WIDTH, phase_width[p]);
        write_dim(CFG_MAP_HEIGHT, phase_height[p]);
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        rad = $urandom_range(0, 1) ? int'($urandom_range(0, 31)) : int'($urandom_range(0, 4));
        send_circle(pick_coord(phase_width[p]), pick_coord(phase_height[p]), rad);
        if (p < PHASES - 1 && k % 12 < 8 && $urandom_range(0, 2) == 0)
          hold_off($urandom_range(1, 7));
        else if (p < PHASES - 1 && $urandom_range(0, 30) == 0)
          wait_drain();
      end
      wait_drain();
    end

    $display("Covered %0d circles over %0d map sizes (zero, one, full and oversized among them)",
             circles_sent, PHASES);
    $display("Checked %0d scanlines, %0d of them visible", lines_checked, lines_visible);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ hex_circle_span_generator_unit.f @@
+incdir+hw/rtl
hw/rtl/hcsg_pkg.sv
hw/rtl/hcsg_ctrl.sv
hw/rtl/hcsg_datapath.sv
hw/rtl/hex_circle_span_generator_unit.sv
test/hcsg_span_checker.sv
test/tb_hex_circle_span_generator_unit.sv
